### hw/rtl/multi_waveform_oscillator_core_macros.svh
// ----------------------------------------------------------------------------
// Oscillator assertion macros
// Shared concurrent assertion forms. The using module provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef MULTI_WAVEFORM_OSCILLATOR_CORE_MACROS_SVH
`define MULTI_WAVEFORM_OSCILLATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MWO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MWO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mwo_pkg.sv
// ----------------------------------------------------------------------------
// Oscillator package
// Register indexes, waveform codes, shared structs and the sine table builder.
// ----------------------------------------------------------------------------
package mwo_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_WAVE_SELECT  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TOTAL_FRAMES = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FADE_FRAMES  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FADE_STEP    = 3'd5;

  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_SQUARE   = 3'd1;
  localparam logic [2:0] WAVE_SAW      = 3'd2;
  localparam logic [2:0] WAVE_RAMP     = 3'd3;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd4;

  localparam logic [16:0] GAIN_ONE = 17'd65536;
  localparam logic [15:0] AMP_ONE  = 16'd32768;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Queue of two entries between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  typedef struct packed {
    logic [2:0]  wave_select;
    logic [31:0] phase_step;
    logic [15:0] amplitude;
    logic [29:0] total_frames;
    logic [8:0]  fade_frames;
    logic [16:0] fade_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    wave_select:  3'd0,
    phase_step:   32'd0,
    amplitude:    16'd0,
    total_frames: 30'd1,
    fade_frames:  9'd1,
    fade_step:    17'd65536
  };

  // Per-frame control handed from front to back.
  typedef struct packed {
    logic        active;
    logic        last;
    logic [16:0] gin;
    logic [16:0] gout;
  } ctrl_t;

  // Quarter-wave sine entry k: Taylor series through x^13 in Q30, scaled to
  // full scale 2^(sample_bits-1) with round half up, limited to full scale.
  function automatic logic [24:0] sine_entry(input int unsigned k,
                                             input int unsigned tbl_bits,
                                             input int unsigned sample_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        prod;
    logic signed [63:0] acc;
    logic signed [63:0] fs;
    logic signed [63:0] e;
    x    = (HALF_PI_Q30 * 64'(k) + (64'd1 << (tbl_bits - 1))) >> tbl_bits;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    acc  = $signed(x);
    for (int n = 1; n <= 6; n++) begin
      prod = (term * x2) >> 30;
      case (n)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        default: term = prod / 64'd156;
      endcase
      if ((n % 2) == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    fs = 64'sd1 <<< (sample_bits - 1);
    e  = (acc * fs + (64'sd1 <<< 29)) >>> 30;
    if (e > fs) begin
      e = fs;
    end
    return e[24:0];
  endfunction

endpackage

### hw/rtl/multi_waveform_oscillator_core.sv
// ----------------------------------------------------------------------------
// Multi-waveform oscillator core
// Phase-accumulator tone generator with sine, square, saw, ramp and triangle
// waveforms, amplitude scaling and linear fade-in and fade-out.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  -------  ---------  ------------------------------------------------------
//  in_      slave      tdata[0] start_req (1 = new tone, 0 = next frame)
//  out_     master     tdata = sample, tuser[0] = active, tlast = last frame
//  cfg_     write      cfg_addr selects register 0..5, cfg_wdata is the value
//
//  The front end pushes each frame tick into the queue in the cycle it accepts
//  it; the back end works through it (pop, sine table read, waveform, three
//  passes through one shared multiplier, output load) and takes no new frame
//  until done. A two-entry queue lets the input run ahead of the back end.
//  The output register holds a result while out_tready is low; the back end
//  waits in its output step, and the queue then fills and drops in_tready.
//  Reset (rst_n low, synchronous) clears the tone state, the queue and the
//  output valid; registers return to their documented defaults.
// ----------------------------------------------------------------------------
`include "multi_waveform_oscillator_core_macros.svh"

module multi_waveform_oscillator_core #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // [0] start_req
  // Result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     out_tdata,  // sample, zero-padded
  output logic [0:0]                           out_tuser,  // [0] active
  output logic                                 out_tlast,
  // Configuration write port
  input  logic                                 cfg_we,
  input  logic [mwo_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int ENT_W = PHASE_BITS + $bits(mwo_pkg::ctrl_t);

  mwo_pkg::cfg_t cfg_r;

  logic                          f_push;
  logic [PHASE_BITS-1:0]         f_phase;
  mwo_pkg::ctrl_t                f_ctrl;
  logic                          q_full;
  logic                          q_empty;
  logic                          q_pop;
  logic [ENT_W-1:0]              q_dout;
  logic signed [SAMPLE_BITS-1:0] b_sample;
  logic                          b_active;
  logic                          b_last;

  // Register file: take writes by index, ignore unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= mwo_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        mwo_pkg::REG_WAVE_SELECT:  cfg_r.wave_select  <= cfg_wdata[2:0];
        mwo_pkg::REG_PHASE_STEP:   cfg_r.phase_step   <= cfg_wdata[31:0];
        mwo_pkg::REG_AMPLITUDE:    cfg_r.amplitude    <= cfg_wdata[15:0];
        mwo_pkg::REG_TOTAL_FRAMES: cfg_r.total_frames <= cfg_wdata[29:0];
        mwo_pkg::REG_FADE_FRAMES:  cfg_r.fade_frames  <= cfg_wdata[8:0];
        mwo_pkg::REG_FADE_STEP:    cfg_r.fade_step    <= cfg_wdata[16:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: advance phase and frame count, work out gains per frame.
  mwo_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .start_req (in_tdata[0]),
    .q_push    (f_push),
    .q_phase   (f_phase),
    .q_ctrl    (f_ctrl),
    .q_full    (q_full)
  );

  // Decouple the tick side from the sample arithmetic.
  mwo_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   ({f_phase, f_ctrl}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // Back end: waveform, gain chain, saturation, output register.
  mwo_back #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_phase    (q_dout[ENT_W-1 -: PHASE_BITS]),
    .q_ctrl     (mwo_pkg::ctrl_t'(q_dout[$bits(mwo_pkg::ctrl_t)-1:0])),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (b_sample),
    .out_active (b_active),
    .out_last   (b_last)
  );

  assign out_tdata    = OUT_W'($unsigned(b_sample));
  assign out_tuser[0] = b_active;
  assign out_tlast    = b_last;

  `MWO_ASSERT_NOW(a_idle_is_silent, out_tvalid && !out_tuser[0], (out_tdata == '0) && !out_tlast, "idle transaction carries data")
  `MWO_ASSERT_NOW(a_last_is_active, out_tvalid && out_tlast, out_tuser[0], "last frame flagged outside a tone")

endmodule

### hw/rtl/mwo_queue.sv
// ----------------------------------------------------------------------------
// Oscillator frame queue
// Two-entry FIFO that lets the frame front end and the sample back end stall
// independently.
// ----------------------------------------------------------------------------
module mwo_queue #(
  parameter int WIDTH = 68
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0]          mem [mwo_pkg::Q_DEPTH];
  logic [mwo_pkg::Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [mwo_pkg::Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [mwo_pkg::Q_AW:0]    count_r, count_nxt;

  assign full  = (count_r == (mwo_pkg::Q_AW + 1)'(mwo_pkg::Q_DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (push ? 1'b1 : 1'b0);
    rd_ptr_nxt = rd_ptr_r + (pop ? 1'b1 : 1'b0);
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

### hw/rtl/mwo_front.sv
// ----------------------------------------------------------------------------
// Oscillator frame front end
// Accepts frame ticks, tracks phase and frame count, and works out the fade
// gains and end-of-tone flag for each frame.
// ----------------------------------------------------------------------------
`include "multi_waveform_oscillator_core_macros.svh"

module mwo_front #(
  parameter int PHASE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mwo_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  start_req,
  output logic                  q_push,
  output logic [PHASE_BITS-1:0] q_phase,
  output mwo_pkg::ctrl_t        q_ctrl,
  input  logic                  q_full
);

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [29:0]           frame_r, frame_nxt;
  logic                  running_r, running_nxt;

  logic                  run;
  logic [29:0]           fi;
  logic [PHASE_BITS-1:0] ph;
  logic [29:0]           tot;
  logic [29:0]           tm1;
  logic [8:0]            fl;
  logic                  is_last;
  logic [16:0]           gin;
  logic [16:0]           gout;

  // Linear fade gain in Q1.16 at distance pos from the tone edge.
  function automatic logic [16:0] fade_gain(input logic [29:0] pos,
                                            input logic [8:0]  len,
                                            input logic [16:0] step);
    logic [25:0] prod;
    prod = pos[8:0] * step;
    if (pos >= 30'(len)) begin
      return mwo_pkg::GAIN_ONE;
    end
    if (prod > 26'(mwo_pkg::GAIN_ONE)) begin
      return mwo_pkg::GAIN_ONE;
    end
    return prod[16:0];
  endfunction

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    // A start clears phase and count before this frame plays.
    run     = start_req || running_r;
    fi      = start_req ? '0 : frame_r;
    ph      = start_req ? '0 : phase_r;
    tot     = (cfg.total_frames == '0) ? 30'd1 : cfg.total_frames;
    tm1     = tot - 30'd1;
    fl      = (cfg.fade_frames == '0) ? 9'd1 : cfg.fade_frames;
    is_last = (fi >= tm1);
    gin     = fade_gain(fi, fl, cfg.fade_step);
    gout    = (fi <= tm1) ? fade_gain(tm1 - fi, fl, cfg.fade_step) : '0;

    q_phase      = ph;
    q_ctrl.active = run;
    q_ctrl.last   = run && is_last;
    q_ctrl.gin    = run ? gin : '0;
    q_ctrl.gout   = run ? gout : '0;

    phase_nxt   = phase_r;
    frame_nxt   = frame_r;
    running_nxt = running_r;
    if (q_push && run) begin
      if (is_last) begin
        // Stop the tone; phase and count freeze.
        running_nxt = 1'b0;
        phase_nxt   = ph;
        frame_nxt   = fi;
      end else begin
        running_nxt = 1'b1;
        phase_nxt   = ph + PHASE_BITS'(cfg.phase_step);
        frame_nxt   = fi + 30'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      frame_r   <= '0;
      running_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      frame_r   <= frame_nxt;
      running_r <= running_nxt;
    end
  end

  `MWO_ASSERT_NEXT(a_last_stops_tone, q_push && q_ctrl.last, !running_r, "tone still running after last frame")

endmodule

### hw/rtl/mwo_back.sv
// ----------------------------------------------------------------------------
// Oscillator sample back end
// Reads the waveform for a queued frame, applies amplitude and fade gains on
// one shared multiplier, saturates, and holds the result for the output.
// ----------------------------------------------------------------------------
module mwo_back #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mwo_pkg::cfg_t                 cfg,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic [PHASE_BITS-1:0]         q_phase,
  input  mwo_pkg::ctrl_t                q_ctrl,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_active,
  output logic                          out_last
);

  localparam int S  = SAMPLE_BITS;
  localparam int TB = SINE_TABLE_BITS;
  localparam int N  = 1 << TB;
  localparam int PW = S + 19;

  localparam logic signed [S+1:0] FS_W  = (S + 2)'(1) <<< (S - 1);
  localparam logic signed [S:0]   FS    = (S + 1)'(1) <<< (S - 1);
  localparam logic signed [S:0]   FS_M1 = FS - (S + 1)'(1);
  localparam logic signed [S:0]   FS_NEG = -FS;
  localparam logic signed [PW-1:0] HALF15 = PW'(1) <<< 14;
  localparam logic signed [PW-1:0] HALF16 = PW'(1) <<< 15;
  localparam logic [TB:0]         N_K   = (TB + 1)'(N);

  typedef logic [S-1:0] rom_t [N+1];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= N; k++) begin
      r[k] = S'(mwo_pkg::sine_entry(k, TB, S));
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  typedef enum logic [2:0] {
    B_IDLE, B_LOOK, B_WAVE, B_AMP, B_GIN, B_GOUT, B_OUT
  } bstate_t;

  bstate_t               state_r;
  logic [PHASE_BITS-1:0] ph_r;
  mwo_pkg::ctrl_t        ctrl_r;
  logic [S-1:0]          rom_r;
  logic signed [S:0]     v_r;
  logic                  out_valid_r;
  logic signed [S-1:0]   out_sample_r;
  logic                  out_active_r;
  logic                  out_last_r;

  logic [47:0]           p48;
  logic [1:0]            quad;
  logic [TB-1:0]         ti;
  logic [TB:0]           kidx;
  logic [S-1:0]          u;
  logic [S:0]            t;
  logic signed [S+1:0]   w;
  logic [15:0]           amp;
  logic [16:0]           gsel;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  r15;
  logic signed [PW-1:0]  r16;
  logic signed [S:0]     vmul;
  logic signed [S-1:0]   sat;
  logic                  out_free;

  assign p48  = 48'(ph_r) << (48 - PHASE_BITS);
  assign quad = p48[47:46];
  assign ti   = p48[45 -: TB];
  assign kidx = quad[0] ? (N_K - {1'b0, ti}) : {1'b0, ti};
  assign u    = p48[47 -: S];
  assign t    = p48[47 -: (S + 1)];
  assign amp  = (cfg.amplitude > mwo_pkg::AMP_ONE) ? mwo_pkg::AMP_ONE : cfg.amplitude;

  always_comb begin
    case (cfg.wave_select)
      mwo_pkg::WAVE_SINE: begin
        w = quad[1] ? -$signed({2'b00, rom_r}) : $signed({2'b00, rom_r});
      end
      mwo_pkg::WAVE_SQUARE: begin
        w = p48[47] ? -FS_W : FS_W;
      end
      mwo_pkg::WAVE_SAW: begin
        w = $signed({2'b00, u}) - FS_W;
      end
      mwo_pkg::WAVE_RAMP: begin
        w = FS_W - $signed({2'b00, u});
      end
      mwo_pkg::WAVE_TRIANGLE: begin
        w = t[S] ? (FS_W + FS_W + FS_W - $signed({1'b0, t}))
                 : ($signed({1'b0, t}) - FS_W);
      end
      default: begin
        w = '0;
      end
    endcase
  end

  // Shared multiplier: amplitude, then fade-in, then fade-out.
  always_comb begin
    case (state_r)
      B_AMP:   gsel = {1'b0, amp};
      B_GIN:   gsel = ctrl_r.gin;
      default: gsel = ctrl_r.gout;
    endcase
    prod = PW'(v_r) * $signed({1'b0, gsel});
    r15  = (prod + HALF15) >>> 15;
    r16  = (prod + HALF16) >>> 16;
    vmul = (state_r == B_AMP) ? r15[S:0] : r16[S:0];
  end

  always_comb begin
    if (v_r > FS_M1) begin
      sat = FS_M1[S-1:0];
    end else if (v_r < FS_NEG) begin
      sat = FS_NEG[S-1:0];
    end else begin
      sat = v_r[S-1:0];
    end
  end

  assign out_free   = !out_valid_r || out_ready;
  assign q_pop      = (state_r == B_IDLE) && !q_empty;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_active = out_active_r;
  assign out_last   = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new result from the output step, else drop valid once taken.
      if ((state_r == B_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            ph_r    <= q_phase;
            ctrl_r  <= q_ctrl;
            state_r <= B_LOOK;
          end
        end
        B_LOOK: begin
          rom_r   <= SINE_ROM[kidx];
          state_r <= B_WAVE;
        end
        B_WAVE: begin
          v_r     <= w[S:0];
          state_r <= B_AMP;
        end
        B_AMP: begin
          v_r     <= vmul;
          state_r <= B_GIN;
        end
        B_GIN: begin
          v_r     <= vmul;
          state_r <= B_GOUT;
        end
        B_GOUT: begin
          v_r     <= vmul;
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (out_free) begin
            out_sample_r <= ctrl_r.active ? sat : '0;
            out_active_r <= ctrl_r.active;
            out_last_r   <= ctrl_r.last;
            state_r      <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

### test/osc_sample_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Oscillator sample checker
// Follows configuration writes and input transactions, predicts the sample,
// active and last flags of every frame tick, and compares each output
// transaction with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module osc_sample_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [0] start_req
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [15:0]                    out_tdata,  // [15:0] sample
  input  logic [0:0]                     out_tuser,  // [0] active
  input  logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [mwo_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mwo_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             pending
);

  localparam int              TBL_N       = 1024;
  localparam longint          FS          = 32768;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               active;
    logic               last;
  } osc_sample_t;

  longint sine_tbl [0:TBL_N];

  // Shadow registers
  logic [2:0]  wave_sel;
  logic [31:0] step_cfg;
  logic [15:0] amp_cfg;
  logic [29:0] frames_cfg;
  logic [8:0]  fade_len_cfg;
  logic [16:0] fade_inc_cfg;

  // Tone state
  logic [31:0] phase;
  logic [29:0] frame_no;
  logic        playing;

  osc_sample_t expected_samples[$];

  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Quarter-wave entry: Taylor series of sin through x^13 in Q30.
  function automatic longint sine_quarter(input int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          e;
    int              n;
    x    = (PI_HALF_Q30 * longint'(k) + TBL_N / 2) / TBL_N;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    acc  = longint'(x);
    for (n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    e = round_shift(acc * FS, 30);
    if (e > FS) e = FS;
    return e;
  endfunction

  function automatic longint fade_gain(input longint pos, input longint len);
    longint inc;
    longint g;
    inc = fade_inc_cfg;
    if (pos >= len) return 65536;
    g = pos * inc;
    return (g > 65536) ? 65536 : g;
  endfunction

  // Play one frame tick and advance the tone state.
  function automatic osc_sample_t predict_frame(input logic start_req);
    osc_sample_t r;
    longint      tot;
    longint      fl;
    longint      fi;
    longint      amp;
    longint      gin;
    longint      gout;
    longint      w;
    longint      v;
    longint      uu;
    longint      tt;
    logic [1:0]  quad;
    logic [9:0]  idx;
    int          k;
    r = '0;
    if (start_req) begin
      phase    = '0;
      frame_no = '0;
      playing  = 1'b1;
    end
    if (!playing) return r;

    tot = frames_cfg;
    if (tot == 0) tot = 1;
    fl = fade_len_cfg;
    if (fl == 0) fl = 1;
    amp = amp_cfg;
    if (amp > FS) amp = FS;
    fi = frame_no;

    r.last = (fi >= tot - 1);
    gin    = fade_gain(fi, fl);
    gout   = (fi <= tot - 1) ? fade_gain(tot - 1 - fi, fl) : 0;

    uu = phase[31:16];
    tt = phase[31:15];
    case (wave_sel)
      mwo_pkg::WAVE_SINE: begin
        quad = phase[31:30];
        idx  = phase[29:20];
        k    = quad[0] ? TBL_N - int'(idx) : int'(idx);
        w    = quad[1] ? -sine_tbl[k] : sine_tbl[k];
      end
      mwo_pkg::WAVE_SQUARE:   w = phase[31] ? -FS : FS;
      mwo_pkg::WAVE_SAW:      w = uu - FS;
      mwo_pkg::WAVE_RAMP:     w = FS - uu;
      mwo_pkg::WAVE_TRIANGLE: w = (tt < 2 * FS) ? tt - FS : 3 * FS - tt;
      default:                w = 0;
    endcase

    v = round_shift(w * amp, 15);
    v = round_shift(v * gin, 16);
    v = round_shift(v * gout, 16);
    if (v > FS - 1) v = FS - 1;
    if (v < -FS) v = -FS;

    r.sample = v[15:0];
    r.active = 1'b1;

    if (r.last) begin
      playing = 1'b0;
    end else begin
      frame_no = frame_no + 30'd1;
      phase    = phase + step_cfg;
    end
    return r;
  endfunction

  function automatic void report_field(input string name, input longint want,
                                       input longint got);
    mismatches++;
    $error("%s mismatch: expected %0d, actual %0d", name, want, got);
  endfunction

  initial begin
    for (int k = 0; k <= TBL_N; k++) sine_tbl[k] = sine_quarter(k);
  end

  always @(posedge clk) begin
    osc_sample_t want;
    osc_sample_t got;
    if (!rst_n) begin
      wave_sel     = mwo_pkg::CFG_RESET.wave_select;
      step_cfg     = mwo_pkg::CFG_RESET.phase_step;
      amp_cfg      = mwo_pkg::CFG_RESET.amplitude;
      frames_cfg   = mwo_pkg::CFG_RESET.total_frames;
      fade_len_cfg = mwo_pkg::CFG_RESET.fade_frames;
      fade_inc_cfg = mwo_pkg::CFG_RESET.fade_step;
      phase        = '0;
      frame_no     = '0;
      playing      = 1'b0;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          mwo_pkg::REG_WAVE_SELECT:  wave_sel     = cfg_wdata[2:0];
          mwo_pkg::REG_PHASE_STEP:   step_cfg     = cfg_wdata[31:0];
          mwo_pkg::REG_AMPLITUDE:    amp_cfg      = cfg_wdata[15:0];
          mwo_pkg::REG_TOTAL_FRAMES: frames_cfg   = cfg_wdata[29:0];
          mwo_pkg::REG_FADE_FRAMES:  fade_len_cfg = cfg_wdata[8:0];
          mwo_pkg::REG_FADE_STEP:    fade_inc_cfg = cfg_wdata[16:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_samples.push_back(predict_frame(in_tdata[0]));
      if (out_tvalid && out_tready) begin
        got.sample = out_tdata;
        got.active = out_tuser[0];
        got.last   = out_tlast;
        if (expected_samples.size() == 0) begin
          mismatches++;
          $error("output transaction with no prediction waiting: sample %0d",
                 $signed(got.sample));
        end else begin
          want = expected_samples.pop_front();
          if (got.sample !== want.sample)
            report_field("sample", $signed(want.sample), $signed(got.sample));
          if (got.active !== want.active) report_field("active", want.active, got.active);
          if (got.last !== want.last) report_field("last", want.last, got.last);
        end
      end
    end
    pending = expected_samples.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Oscillator core testbench
// Drives frame ticks and register settings into the oscillator core with
// bursty input and a stalling receiver; the sample checker beside the core
// predicts every output transaction and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb;

  // Indexes past the last register; writes there must be ignored.
  localparam logic [mwo_pkg::CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [mwo_pkg::CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;
  // Selector with no waveform behind it.
  localparam logic [2:0]            WAVE_NONE   = 3'd7;
  localparam int                    RANDOM_ITEMS = 1250;
  localparam int                    TONE_CAP     = 48;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata   = '0;   // [0] start_req
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [15:0]                    out_tdata;         // [15:0] sample
  logic [0:0]                     out_tuser;         // [0] active
  logic                           out_tlast;
  logic                           cfg_we     = 1'b0;
  logic [mwo_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [mwo_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;

  int mismatches;
  int pending;

  int sent       = 0;   // accepted input transactions
  int burst_left = 1;   // transactions left in the current input burst
  bit steady     = 1'b0; // no input gaps while set
  int tone_len   = 1;   // effective tone length of the current setting

  int stall_mode  = 0;
  int stall_left  = 0;
  int stall_phase = 0;

  always #5 clk = ~clk;

  multi_waveform_oscillator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  osc_sample_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: switch between stall styles at random, from always ready down
  // to one ready cycle in nine.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 160);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 4) != 0);
      default: out_tready <= (stall_phase % 9 == 0);
    endcase
  end

  // Drop valid for a gap of the given length.
  task automatic pause_input(input int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Offer one frame tick and hold it until the transaction completes; close
  // the burst and insert a gap when its count runs out.
  task automatic send_tick(input logic start_req);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, start_req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) pause_input($urandom_range(1, 8));
    end
  endtask

  task automatic play_tone(input int advances);
    send_tick(1'b1);
    repeat (advances) send_tick(1'b0);
  endtask

  // Hold off until every predicted sample has come back.
  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mwo_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Drain, then write all six registers; now and then poke a spare index too.
  task automatic new_setting(input logic [31:0] wave, input logic [31:0] step,
                             input logic [31:0] amp, input logic [31:0] frames,
                             input logic [31:0] fade_len, input logic [31:0] fade_inc);
    drain();
    write_reg(mwo_pkg::REG_WAVE_SELECT, wave);
    write_reg(mwo_pkg::REG_PHASE_STEP, step);
    write_reg(mwo_pkg::REG_AMPLITUDE, amp);
    write_reg(mwo_pkg::REG_TOTAL_FRAMES, frames);
    write_reg(mwo_pkg::REG_FADE_FRAMES, fade_len);
    write_reg(mwo_pkg::REG_FADE_STEP, fade_inc);
    if ($urandom_range(0, 3) == 0)
      write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    tone_len = (frames[29:0] == 0) ? 1 : int'(frames[29:0]);
  endtask

  // Random setting, weighted toward the extremes of every register.
  task automatic random_setting;
    logic [31:0] wave;
    logic [31:0] step;
    logic [31:0] amp;
    logic [31:0] frames;
    logic [31:0] fade_len;
    logic [31:0] fade_inc;
    wave = ($urandom_range(0, 9) < 8)
           ? $urandom_range(mwo_pkg::WAVE_SINE, mwo_pkg::WAVE_TRIANGLE)
           : $urandom_range(5, 7);
    case ($urandom_range(0, 7))
      0:       step = '0;
      1:       step = '1;
      2:       step = 32'h8000_0000;
      3:       step = $urandom_range(1, 1 << 20);
      default: step = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       amp = 0;
      1:       amp = 32'(mwo_pkg::AMP_ONE);
      2:       amp = 32'h0000_FFFF;
      3:       amp = $urandom_range(0, 16'hFFFF);
      default: amp = $urandom_range(0, mwo_pkg::AMP_ONE);
    endcase
    case ($urandom_range(0, 19))
      0:       frames = 0;
      1:       frames = 32'h3FFF_FFFF;
      2:       frames = 691200000;
      3:       frames = $urandom & 32'h3FFF_FFFF;
      default: frames = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 9))
      0:       fade_len = 0;
      1:       fade_len = 511;
      2:       fade_len = 384;
      3:       fade_len = $urandom_range(0, 511);
      default: fade_len = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 9))
      0:       fade_inc = 0;
      1:       fade_inc = 32'(mwo_pkg::GAIN_ONE);
      2:       fade_inc = 32'h0001_FFFF;
      3:       fade_inc = $urandom_range(0, 17'h1FFFF);
      default: fade_inc = 65536 / ((fade_len == 0) ? 1 : fade_len);
    endcase
    // Junk above each register's width must be dropped.
    if ($urandom_range(0, 3) == 0) begin
      wave     = wave     | ($urandom << 3);
      amp      = amp      | ($urandom << 16);
      frames   = frames   | ($urandom << 30);
      fade_len = fade_len | ($urandom << 9);
      fade_inc = fade_inc | ($urandom << 17);
    end
    new_setting(wave, step, amp, frames, fade_len, fade_inc);
  endtask

  initial begin
    int target;
    int span;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Idle tick before any tone, then a one-frame tone on reset values.
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);

    // Every waveform over three frames; the middle frame runs at full gain.
    // Triangle also gets an amplitude above unity.
    for (int w = mwo_pkg::WAVE_SINE; w <= mwo_pkg::WAVE_TRIANGLE; w++) begin
      new_setting(w, 32'h5555_5555,
                  (w == mwo_pkg::WAVE_TRIANGLE) ? 32'hFFFF : 32'(mwo_pkg::AMP_ONE), 3, 1,
                  32'(mwo_pkg::GAIN_ONE));
      play_tone(2);
    end

    // Unused selector: still active, sample stays zero.
    new_setting(32'(WAVE_NONE), 32'h1234_5678, 32'(mwo_pkg::AMP_ONE), 3, 1,
                32'(mwo_pkg::GAIN_ONE));
    play_tone(2);

    // Zero tone length and zero fade length both act as one.
    new_setting(32'(mwo_pkg::WAVE_SQUARE), 0, 32'(mwo_pkg::AMP_ONE), 0, 0,
                32'(mwo_pkg::GAIN_ONE));
    play_tone(0);

    // Shorten the tone under a running frame: the next frame ends it silent.
    new_setting(32'(mwo_pkg::WAVE_SAW), 32'h0123_4567, 32'(mwo_pkg::AMP_ONE), 40, 4, 16384);
    play_tone(3);
    new_setting(32'(mwo_pkg::WAVE_SAW), 32'h0123_4567, 32'(mwo_pkg::AMP_ONE), 2, 4, 16384);
    send_tick(1'b0);

    // Random settings, each followed by mostly complete tones; a broken tone
    // may be carried into the next setting.
    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      random_setting();
      steady = ($urandom_range(0, 3) == 0);
      span   = (tone_len < TONE_CAP) ? tone_len : TONE_CAP;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) send_tick(1'b0);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(0, 1)));
          1: play_tone($urandom_range(0, span - 1));
          default: begin
            play_tone(span - 1);
            repeat ($urandom_range(0, 2)) send_tick(1'b0);
          end
        endcase
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
